@@ design/gbte_pkg.sv @@
`timescale 1ns / 1ps
package gbte_pkg;

  localparam int CAPACITY    = 4096;
  localparam int ADDR_W      = 12;
  localparam int FIELD_W     = 13;
  localparam int MAX_PATTERN = 8;
  localparam int PAT_W       = 8 * MAX_PATTERN;
  localparam int LEN_W       = 4;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  localparam logic [3:0] CMD_INSERT    = 4'd0;
  localparam logic [3:0] CMD_BACKSPACE = 4'd1;
  localparam logic [3:0] CMD_LEFT      = 4'd2;
  localparam logic [3:0] CMD_RIGHT     = 4'd3;
  localparam logic [3:0] CMD_LINES     = 4'd4;
  localparam logic [3:0] CMD_LINE_LEN  = 4'd5;
  localparam logic [3:0] CMD_FIND_FWD  = 4'd6;
  localparam logic [3:0] CMD_FIND_BACK = 4'd7;
  localparam logic [3:0] CMD_TO_SCREEN = 4'd8;
  localparam logic [3:0] CMD_TO_INDEX  = 4'd9;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic REG_PAT_TEXT = 1'b0;
  localparam logic REG_PAT_LEN  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic move_wr;
    logic scan;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_scan;
    logic is_move;
    logic move_ok;
    logic scan_end;
  } dp_stat_t;

endpackage

@@ design/gbte_if.sv @@
`timescale 1ns / 1ps
interface gbte_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [7:0]  ch;
  logic [12:0] position;
  logic [12:0] row;
  logic [12:0] col;
  modport source (output valid, cmd, ch, position, row, col, input ready);
  modport sink (input valid, cmd, ch, position, row, col, output ready);
endinterface

interface gbte_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [12:0] value;
  logic [12:0] row_out;
  logic [12:0] col_out;
  logic [12:0] gap_front_now;
  logic [12:0] gap_back_now;
  modport source (output valid, status, value, row_out, col_out, gap_front_now,
                  gap_back_now, input ready);
  modport sink (input valid, status, value, row_out, col_out, gap_front_now,
                gap_back_now, output ready);
endinterface

@@ design/gbte_ctrl.sv @@
`timescale 1ns / 1ps
module gbte_ctrl
  import gbte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_MOVE_WR = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.latch    = (state_r == S_IDLE) && in_valid;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_move && stat.move_ok) state_nxt = S_MOVE_WR;
        else if (stat.is_scan) state_nxt = S_SCAN;
        else state_nxt = S_DONE;
      end
      S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/gbte_datapath.sv @@
`timescale 1ns / 1ps
module gbte_datapath
  import gbte_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  ctl_cmd_t     cmd,
  output dp_stat_t     stat,
  input  logic [3:0]   in_cmd,
  input  logic [7:0]   in_ch,
  input  logic [12:0]  in_position,
  input  logic [12:0]  in_row,
  input  logic [12:0]  in_col,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_wdata,
  output logic [1:0]   out_status,
  output logic [12:0]  out_value,
  output logic [12:0]  out_row,
  output logic [12:0]  out_col,
  output logic [12:0]  out_gap_front,
  output logic [12:0]  out_gap_back
);

  localparam logic [FIELD_W-1:0] CAP_F = FIELD_W'(CAPACITY);
  localparam logic [ADDR_W-1:0]  LAST_SEQ = {ADDR_W{1'b1}};

  logic [7:0] mem [CAPACITY];
  logic [7:0] rd_data_r;

  logic [3:0]         cmd_r;
  logic [7:0]         ch_r;
  logic [FIELD_W-1:0] pos_r, row_r, col_r;
  logic [FIELD_W-1:0] gf_r, gf_nxt, gb_r, gb_nxt;
  logic [PAT_W-1:0]   pat_r;
  logic [LEN_W-1:0]   plen_r;

  logic [FIELD_W-1:0] cnt_r, cnt_nxt;
  logic               vld_d_r, vld_d_nxt;
  logic [ADDR_W-1:0]  idx_d_r, idx_d_nxt;
  logic               last_d_r, last_d_nxt;

  logic [FIELD_W-1:0] acc_r, acc_nxt, r_r, r_nxt, c_r, c_nxt;
  logic [LEN_W-1:0]   wc_r, wc_nxt;
  logic [7:0]         w_r [MAX_PATTERN];
  logic [7:0]         w_nxt [MAX_PATTERN];
  logic [ADDR_W-1:0]  wi_r [MAX_PATTERN];
  logic [ADDR_W-1:0]  wi_nxt [MAX_PATTERN];
  logic               stop_r, stop_nxt, found_r, found_nxt;
  logic [1:0]         res_r, res_nxt;

  logic               we;
  logic [ADDR_W-1:0]  wa, ra;
  logic [7:0]         wd;

  logic [LEN_W-1:0]   len;
  logic               ing, nl, match_f, match_b;
  logic [FIELD_W-1:0] idx_f;
  logic [7:0]         nw [MAX_PATTERN];
  logic [ADDR_W-1:0]  nwi [MAX_PATTERN];
  logic [LEN_W-1:0]   nwc;
  logic [2:0]         sel;
  logic               desc;

  logic [1:0]         o_status_r;
  logic [FIELD_W-1:0] o_value_r, o_row_r, o_col_r, o_gf_r, o_gb_r;

  assign len   = (plen_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_r;
  assign idx_f = {1'b0, idx_d_r};
  assign ing   = (idx_f >= gf_r) && (idx_f < gb_r);
  assign nl    = (rd_data_r == NEWLINE_BYTE);
  assign desc  = (cmd_r == CMD_FIND_BACK);

  assign stat.is_scan  = (cmd_r >= CMD_LINES) && (cmd_r <= CMD_TO_INDEX);
  assign stat.is_move  = (cmd_r == CMD_LEFT) || (cmd_r == CMD_RIGHT);
  assign stat.move_ok  = (cmd_r == CMD_LEFT) ? ((gf_r != '0) && (gb_r != '0))
                                             : ((gb_r < CAP_F) && (gf_r < CAP_F));
  assign stat.scan_end = vld_d_r && last_d_r;

  // Window of the most recent text bytes, newest in entry zero.
  always_comb begin
    nw[0]  = rd_data_r;
    nwi[0] = idx_d_r;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      nw[k]  = w_r[k-1];
      nwi[k] = wi_r[k-1];
    end
    nwc = (wc_r >= LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : wc_r + 1'b1;
  end

  // Forward matching reads the window oldest first; backward newest first.
  always_comb begin
    match_f = (len != '0) && (nwc >= len);
    match_b = (len != '0) && (nwc >= len);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (LEN_W'(k) < len) begin
        match_f = match_f && (nw[3'(len - 4'd1 - LEN_W'(k))] == pat_r[8*k +: 8]);
        match_b = match_b && (nw[k] == pat_r[8*k +: 8]);
      end
    end
    sel = 3'(len - 4'd1);
  end

  always_comb begin
    gf_nxt     = gf_r;
    gb_nxt     = gb_r;
    cnt_nxt    = cnt_r;
    vld_d_nxt  = 1'b0;
    idx_d_nxt  = idx_d_r;
    last_d_nxt = last_d_r;
    acc_nxt    = acc_r;
    r_nxt      = r_r;
    c_nxt      = c_r;
    wc_nxt     = wc_r;
    stop_nxt   = stop_r;
    found_nxt  = found_r;
    res_nxt    = res_r;
    we         = 1'b0;
    wa         = gf_r[ADDR_W-1:0];
    wd         = ch_r;
    ra         = desc ? ~cnt_r[ADDR_W-1:0] : cnt_r[ADDR_W-1:0];
    for (int k = 0; k < MAX_PATTERN; k++) begin
      w_nxt[k]  = w_r[k];
      wi_nxt[k] = wi_r[k];
    end

    if (cmd.exec) begin
      res_nxt   = ST_DONE;
      cnt_nxt   = '0;
      r_nxt     = '0;
      c_nxt     = '0;
      wc_nxt    = '0;
      stop_nxt  = 1'b0;
      found_nxt = 1'b0;
      acc_nxt   = '0;
      if (cmd_r == CMD_LINES) acc_nxt = FIELD_W'(1);
      if (cmd_r == CMD_TO_INDEX) acc_nxt = CAP_F;
      case (cmd_r)
        CMD_INSERT: begin
          if (gf_r < gb_r) begin
            we     = 1'b1;
            gf_nxt = gf_r + 1'b1;
          end else begin
            res_nxt = ST_REFUSED;
          end
        end
        CMD_BACKSPACE: begin
          if (gf_r != '0) gf_nxt = gf_r - 1'b1;
          else res_nxt = ST_REFUSED;
        end
        CMD_LEFT: begin
          ra = ADDR_W'(gf_r - 1'b1);
          if (!stat.move_ok) res_nxt = ST_REFUSED;
        end
        CMD_RIGHT: begin
          ra = gb_r[ADDR_W-1:0];
          if (!stat.move_ok) res_nxt = ST_REFUSED;
        end
        default: ;
      endcase
    end

    if (cmd.move_wr) begin
      we = 1'b1;
      wd = rd_data_r;
      if (cmd_r == CMD_LEFT) begin
        wa     = ADDR_W'(gb_r - 1'b1);
        gf_nxt = gf_r - 1'b1;
        gb_nxt = gb_r - 1'b1;
      end else begin
        wa     = gf_r[ADDR_W-1:0];
        gf_nxt = gf_r + 1'b1;
        gb_nxt = gb_r + 1'b1;
      end
    end

    if (cmd.scan) begin
      // Issue one read a cycle; the data comes back in the next cycle.
      if (!cnt_r[ADDR_W]) begin
        cnt_nxt    = cnt_r + 1'b1;
        vld_d_nxt  = 1'b1;
        idx_d_nxt  = ra;
        last_d_nxt = (cnt_r[ADDR_W-1:0] == LAST_SEQ);
      end
      if (vld_d_r) begin
        case (cmd_r)
          CMD_LINES: begin
            if (!ing && nl) acc_nxt = acc_r + 1'b1;
          end
          CMD_LINE_LEN: begin
            if (!ing && !stop_r) begin
              if (r_r == row_r) begin
                if (nl) stop_nxt = 1'b1;
                else acc_nxt = acc_r + 1'b1;
              end else if (nl) begin
                r_nxt = r_r + 1'b1;
              end
            end
          end
          CMD_FIND_FWD: begin
            if (!stop_r && !ing && (idx_f >= pos_r)) begin
              wc_nxt = nwc;
              for (int k = 0; k < MAX_PATTERN; k++) begin
                w_nxt[k]  = nw[k];
                wi_nxt[k] = nwi[k];
              end
              if (match_f) begin
                acc_nxt   = {1'b0, nwi[sel]};
                stop_nxt  = 1'b1;
                found_nxt = 1'b1;
              end
            end
          end
          CMD_FIND_BACK: begin
            if (!stop_r) begin
              if (ing || (idx_f > pos_r)) begin
                wc_nxt = '0;
              end else begin
                wc_nxt = nwc;
                for (int k = 0; k < MAX_PATTERN; k++) w_nxt[k] = nw[k];
                if (match_b) begin
                  acc_nxt   = idx_f;
                  stop_nxt  = 1'b1;
                  found_nxt = 1'b1;
                end
              end
            end
          end
          CMD_TO_SCREEN: begin
            if (!ing && (idx_f < pos_r)) begin
              if (nl) begin
                r_nxt = r_r + 1'b1;
                c_nxt = '0;
              end else begin
                c_nxt = c_r + 1'b1;
              end
            end
          end
          CMD_TO_INDEX: begin
            if (!ing && !stop_r) begin
              if ((r_r == row_r) && (c_r == col_r)) begin
                acc_nxt  = idx_f;
                stop_nxt = 1'b1;
              end else if (nl) begin
                r_nxt = r_r + 1'b1;
                c_nxt = '0;
              end else begin
                c_nxt = c_r + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gf_r    <= '0;
      gb_r    <= CAP_F;
      pat_r   <= '0;
      plen_r  <= '0;
      vld_d_r <= 1'b0;
    end else begin
      gf_r    <= gf_nxt;
      gb_r    <= gb_nxt;
      vld_d_r <= vld_d_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_PAT_TEXT) pat_r <= cfg_wdata;
        if (cfg_index == REG_PAT_LEN) plen_r <= cfg_wdata[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_cmd;
      ch_r  <= in_ch;
      pos_r <= in_position;
      row_r <= in_row;
      col_r <= in_col;
    end
    cnt_r    <= cnt_nxt;
    idx_d_r  <= idx_d_nxt;
    last_d_r <= last_d_nxt;
    acc_r    <= acc_nxt;
    r_r      <= r_nxt;
    c_r      <= c_nxt;
    wc_r     <= wc_nxt;
    stop_r   <= stop_nxt;
    found_r  <= found_nxt;
    res_r    <= res_nxt;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      w_r[k]  <= w_nxt[k];
      wi_r[k] <= wi_nxt[k];
    end
    if (cmd.load_out) begin
      if ((cmd_r == CMD_FIND_FWD) || (cmd_r == CMD_FIND_BACK))
        o_status_r <= found_r ? ST_DONE : ST_NOT_FOUND;
      else
        o_status_r <= res_r;
      o_value_r <= (cmd_r == CMD_TO_SCREEN) ? '0 : acc_r;
      o_row_r   <= (cmd_r == CMD_TO_SCREEN) ? r_r : '0;
      o_col_r   <= (cmd_r == CMD_TO_SCREEN) ? c_r : '0;
      o_gf_r    <= gf_r;
      o_gb_r    <= gb_r;
    end
  end

  assign out_status    = o_status_r;
  assign out_value     = o_value_r;
  assign out_row       = o_row_r;
  assign out_col       = o_col_r;
  assign out_gap_front = o_gf_r;
  assign out_gap_back  = o_gb_r;

endmodule

@@ design/gap_buffer_text_engine.sv @@
// A gap move does one memory read and then one write.
// Queries sweep all 4096 store entries through the single read port, one a cycle.
// One command is in flight at a time; the result register frees the input side.
// Reset is synchronous, active low: empty text, gap over the whole store, pattern
// cleared; store contents are left as they are, with no clearing pass.
`timescale 1ns / 1ps
module gap_buffer_text_engine
  import gbte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  gbte_in_if.sink    in_chan,
  gbte_out_if.source out_chan,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [63:0] cfg_wdata
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  gbte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (ctl)
  );

  gbte_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (ctl),
    .stat          (stat),
    .in_cmd        (in_chan.cmd),
    .in_ch         (in_chan.ch),
    .in_position   (in_chan.position),
    .in_row        (in_chan.row),
    .in_col        (in_chan.col),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_status    (out_chan.status),
    .out_value     (out_chan.value),
    .out_row       (out_chan.row_out),
    .out_col       (out_chan.col_out),
    .out_gap_front (out_chan.gap_front_now),
    .out_gap_back  (out_chan.gap_back_now)
  );

endmodule

@@ design/gbte_checker.sv @@
`timescale 1ns / 1ps
module gbte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [12:0] out_gf,
  input logic [12:0] out_gb
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status code");

  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gf <= out_gb)
    else $error("gap bounds crossed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gap_buffer_text_engine gbte_checker u_gbte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_gf     (out_chan.gap_front_now),
  .out_gb     (out_chan.gap_back_now)
);
